[sv/zbps_pkg.sv]
// Shared types, constants and helper functions for the z-buffer point splat shader.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package zbps_pkg;

  // Number formats
  localparam int COORD_FRAC_BITS = 12;
  localparam int COORD_W         = 16;
  localparam int TRIG_W          = 14;
  localparam int TRIG_FRAC       = 12;
  localparam int ROT_W           = 20;                 // rotated value, full range
  localparam int PROD_W          = ROT_W + TRIG_W + 1; // sum of two products
  localparam int DEPTH_W         = 16;
  localparam int TONE_W          = 4;
  localparam int IDX_W           = 14;
  localparam int COLS_REG_W      = 9;
  localparam int ROWS_REG_W      = 7;
  localparam int SCALE_W         = 16;
  localparam int CFG_ADDR_W      = 5;
  localparam int CFG_DATA_W      = 32;

  // Size defaults for the top level
  localparam int MAX_COLUMNS_DEF = 256;
  localparam int MAX_ROWS_DEF    = 64;

  // Projection
  localparam longint CAM_DIST   = ((longint'(42) << COORD_FRAC_BITS) + 5) / 10;
  localparam longint NEAR_LIMIT = ((longint'(2) << COORD_FRAC_BITS) + 5) / 10;
  localparam int CAM_W   = $clog2(CAM_DIST + 1);
  localparam int DEN_W   = ROT_W + 2;
  localparam int MAG_W   = ROT_W;
  localparam int P1_W    = MAG_W + SCALE_W;
  localparam int P2_W    = P1_W + CAM_W;
  localparam int DEN_SH  = COORD_FRAC_BITS + 8;
  localparam int DIV_W   = 64;
  localparam int Q_W     = 24;
  localparam int SC_W    = Q_W + 2;

  // Shading
  localparam int A_W     = ROT_W + 12;           // 9 * dot product, signed
  localparam int AM_W    = A_W - 1;
  localparam int S_W     = 2 * ROT_W + 2;        // squared normal length
  localparam int BSQ_W   = 20;
  localparam int BB_W    = BSQ_W + S_W;
  localparam int AA_W    = 2 * AM_W;
  localparam int CMP_W   = (BB_W > AA_W) ? BB_W : AA_W;
  localparam longint SMALL_NORM_SQ =
    ((longint'(1) << (2 * COORD_FRAC_BITS)) - 1) / 100000000;
  localparam longint NORM_ONE_SQ   = longint'(1) << (2 * COORD_FRAC_BITS);
  localparam int TONE_STEPS = 9;

  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};
  localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};

  typedef enum logic [1:0] {
    MODE_PLOT  = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_YAW_COS  = 3'd0,
    REG_YAW_SIN  = 3'd1,
    REG_TILT_COS = 3'd2,
    REG_TILT_SIN = 3'd3,
    REG_COLUMNS  = 3'd4,
    REG_ROWS     = 3'd5,
    REG_SCALE    = 3'd6
  } reg_t;

  typedef struct packed {
    mode_t                     mode;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] normal_x;
    logic signed [COORD_W-1:0] normal_y;
    logic signed [COORD_W-1:0] normal_z;
    logic                      is_hole;
    logic [IDX_W-1:0]          target_cell;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]          cell_index;
    logic [TONE_W-1:0]         cell_tone;
    logic signed [DEPTH_W-1:0] cell_depth;
    logic                      wrote;
  } out_item_t;

  // one word of the cell store
  typedef struct packed {
    logic signed [DEPTH_W-1:0] depth;
    logic [TONE_W-1:0]         tone;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  typedef enum logic [4:0] {
    S_SWEEP,
    S_IDLE,
    S_ROT_A,
    S_ROT_B,
    S_PERSP,
    S_SCALE,
    S_DIVGO,
    S_DIV,
    S_PLACE,
    S_INDEX,
    S_SHADE,
    S_SHADE_WAIT,
    S_MEM_RD,
    S_MEM_CHK,
    S_CELL_CLR,
    S_CELL_RD,
    S_CELL_WAIT,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_PREP,
    T_SQUARE,
    T_MUL,
    T_CMP
  } tone_state_t;

  // a*ca + b*cb, rounded to nearest (halves up) after dropping the trig fraction
  function automatic logic signed [ROT_W-1:0] rot_sum(
    input logic signed [ROT_W-1:0]  a,
    input logic signed [TRIG_W-1:0] ca,
    input logic signed [ROT_W-1:0]  b,
    input logic signed [TRIG_W-1:0] cb
  );
    logic signed [PROD_W-1:0] acc;
    acc = PROD_W'(a) * PROD_W'(ca) + PROD_W'(b) * PROD_W'(cb);
    acc = acc + PROD_W'(longint'(1) << (TRIG_FRAC - 1));
    return ROT_W'(acc >>> TRIG_FRAC);
  endfunction

  // squared light thresholds, (2j - 9) * 100 squared
  function automatic logic [BSQ_W-1:0] thr_sq(input logic [3:0] j);
    logic [BSQ_W-1:0] v;
    unique case (j)
      4'd1, 4'd8: v = BSQ_W'(490000);
      4'd2, 4'd7: v = BSQ_W'(250000);
      4'd3, 4'd6: v = BSQ_W'(90000);
      4'd4, 4'd5: v = BSQ_W'(10000);
      4'd9:       v = BSQ_W'(810000);
      default:    v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[sv/zbuffer_point_splat_shader_top.sv]
// Z-buffer point splat shader: rotates, projects and depth-tests points into a
// character-cell store. Uses zbps_pkg, zbps_ram, zbps_div and zbps_tone.
//
// Usage:
//   Items enter on in_valid/in_stall carrying an in_item_t; one result per item
//   leaves on out_valid/out_stall as an out_item_t. Registers are written over
//   the APB-style port (psel/penable/pwrite/paddr/pwdata), 4 bytes apart; the
//   user must write them only while no item is in flight, which the block does
//   not enforce. pready is always high. One item is worked at a time. The two
//   64-step restoring dividers (column and row offsets) and, for a shaded point,
//   the 9-step threshold compare of the tone unit make up most of a plot. A point
//   at the near plane is dropped before the dividers, a clipped one after them.
//   An unused mode or an out-of-range clear or read target goes straight to the
//   result. The cell store is one RAM of MAX_COLUMNS*MAX_ROWS words; each plot
//   that lands reads one word, compares depths and writes it back if deeper.
//   After reset a clearing pass writes every cell to the empty value, one per
//   cycle; in_stall stays high meanwhile.
//   Results sit in an output register; while out_stall is high it holds, and
//   the next item can be taken and worked up to the point of handing over.
`timescale 1ns / 1ps
`default_nettype none

module zbuffer_point_splat_shader_top #(
  parameter int MAX_COLUMNS = zbps_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = zbps_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  zbps_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output zbps_pkg::out_item_t               out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [zbps_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [zbps_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [zbps_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  import zbps_pkg::*;

  localparam int CELLS  = MAX_COLUMNS * MAX_ROWS;
  localparam int AW     = $clog2(CELLS);
  localparam int CW     = $clog2(MAX_COLUMNS + 1);
  localparam int RW     = $clog2(MAX_ROWS + 1);
  localparam int CCMP_W = (CW > COLS_REG_W) ? CW : COLS_REG_W;
  localparam int RCMP_W = (RW > ROWS_REG_W) ? RW : ROWS_REG_W;

  // configuration
  logic signed [TRIG_W-1:0] yaw_cos_r, yaw_sin_r, tilt_cos_r, tilt_sin_r;
  logic [COLS_REG_W-1:0]    columns_r;
  logic [ROWS_REG_W-1:0]    rows_r;
  logic [SCALE_W-1:0]       scale_r;

  state_t state_r, state_nxt;
  logic [AW-1:0] sweep_r;

  in_item_t  item_r;
  logic      nrm_r;
  out_item_t res_r;
  out_item_t out_r;
  logic      out_valid_r;

  logic signed [ROT_W-1:0] rot0_r, rot1_r;
  logic signed [ROT_W-1:0] rx_r, ry_r, rz_r, nx_r, ny_r, nz_r;
  logic signed [DEN_W-1:0] den_r;
  logic [P1_W-1:0]         p1x_r, p1y_r;
  logic [P2_W-1:0]         p2x_r, p2y_r;
  logic                    sgnx_r, sgny_r;
  logic signed [SC_W-1:0]  sx_r, sy_r;
  logic [AW-1:0]           idx_r;
  logic signed [DEPTH_W-1:0] depth_r;

  // memory and units
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  cell_t         mem_wdata, mem_rdata;
  logic          div_start, divx_busy, divy_busy;
  logic [DIV_W-1:0] divx_num, divx_den, divy_num, divy_den, divx_q, divy_q;
  logic          tone_start, tone_busy;
  logic [TONE_W-1:0] tone_q;

  // combinational datapath
  logic [CW-1:0] cols_eff;
  logic [RW-1:0] rows_eff;
  logic signed [ROT_W-1:0] src_x, src_y, src_z;
  logic signed [ROT_W-1:0] rot_y, rot_z;
  logic signed [DEN_W-1:0] den_c;
  logic                    near_c;
  logic [MAG_W-1:0]        magx, magy;
  logic [DIV_W-1:0]        dsh, my13, dy;
  logic signed [SC_W-1:0]  qxs, qys, offx, offy, sx_c, sy_c;
  logic                    clip_c;
  logic                    oor_c;
  logic                    out_free;
  logic                    deeper;
  logic [TONE_W-1:0]       tone_new;
  cell_t                   cell_empty;
  logic                    cfg_wr;

  assign cell_empty = '{depth: DEPTH_MIN, tone: '0};
  assign out_free   = !out_valid_r || !out_stall;
  assign cfg_wr     = psel && penable && pwrite && pready;

  always_comb begin
    cols_eff = (CCMP_W'(columns_r) > CCMP_W'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS)
                                                           : CW'(columns_r);
    rows_eff = (RCMP_W'(rows_r) > RCMP_W'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(rows_r);

    // rotation source: position first, then the normal
    if (nrm_r) begin
      src_x = ROT_W'(item_r.normal_x);
      src_y = ROT_W'(item_r.normal_y);
      src_z = ROT_W'(item_r.normal_z);
    end else begin
      src_x = ROT_W'(item_r.point_x);
      src_y = ROT_W'(item_r.point_y);
      src_z = ROT_W'(item_r.point_z);
    end
    rot_y = rot_sum(src_y, tilt_cos_r, -rot1_r, tilt_sin_r);
    rot_z = rot_sum(src_y, tilt_sin_r, rot1_r, tilt_cos_r);

    den_c  = DEN_W'(CAM_DIST) - DEN_W'(rz_r);
    near_c = den_c <= DEN_W'(NEAR_LIMIT);
    magx   = rx_r[ROT_W-1] ? MAG_W'(-rx_r) : MAG_W'(rx_r);
    magy   = ry_r[ROT_W-1] ? MAG_W'(-ry_r) : MAG_W'(ry_r);

    // rounded quotient = floor((2m + D) / 2D); row divisor carries 25, numerator 13
    dsh      = DIV_W'(den_r) << DEN_SH;
    my13     = (DIV_W'(p2y_r) << 3) + (DIV_W'(p2y_r) << 2) + DIV_W'(p2y_r);
    dy       = (dsh << 4) + (dsh << 3) + dsh;
    divx_num = (DIV_W'(p2x_r) << 1) + dsh;
    divx_den = dsh << 1;
    divy_num = (my13 << 1) + dy;
    divy_den = dy << 1;

    qxs  = $signed(SC_W'(divx_q[Q_W-1:0]));
    qys  = $signed(SC_W'(divy_q[Q_W-1:0]));
    offx = sgnx_r ? -qxs : qxs;
    offy = sgny_r ? -qys : qys;
    sx_c = $signed(SC_W'(cols_eff >> 1)) + offx;
    sy_c = $signed(SC_W'(rows_eff >> 1)) - offy;
    clip_c = (sx_c < SC_W'(1)) || (sx_c >= $signed(SC_W'(cols_eff)) - SC_W'(1)) ||
             (sy_c < SC_W'(0)) || (sy_c >= $signed(SC_W'(rows_eff)));

    oor_c    = 32'(in_item.target_cell) >= 32'(CELLS);
    deeper   = depth_r > $signed(mem_rdata.depth);
    tone_new = item_r.is_hole ? '0 : tone_q;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_SWEEP:      if (sweep_r == AW'(CELLS - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_item.mode)
            MODE_PLOT:  state_nxt = S_ROT_A;
            MODE_CLEAR: state_nxt = oor_c ? S_DONE : S_CELL_CLR;
            MODE_READ:  state_nxt = oor_c ? S_DONE : S_CELL_RD;
            MODE_NONE:  state_nxt = S_DONE;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_ROT_A:      state_nxt = S_ROT_B;
      S_ROT_B:      state_nxt = nrm_r ? S_SHADE : S_PERSP;
      S_PERSP:      state_nxt = near_c ? S_DONE : S_SCALE;
      S_SCALE:      state_nxt = S_DIVGO;
      S_DIVGO:      state_nxt = S_DIV;
      S_DIV:        if (!divx_busy && !divy_busy) state_nxt = S_PLACE;
      S_PLACE:      state_nxt = clip_c ? S_DONE : S_INDEX;
      S_INDEX:      state_nxt = item_r.is_hole ? S_MEM_RD : S_ROT_A;
      S_SHADE:      state_nxt = S_SHADE_WAIT;
      S_SHADE_WAIT: if (!tone_busy) state_nxt = S_MEM_RD;
      S_MEM_RD:     state_nxt = S_MEM_CHK;
      S_MEM_CHK:    state_nxt = S_DONE;
      S_CELL_CLR:   state_nxt = S_DONE;
      S_CELL_RD:    state_nxt = S_CELL_WAIT;
      S_CELL_WAIT:  state_nxt = S_DONE;
      S_DONE:       if (out_free) state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall   = (state_r != S_IDLE);
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = cell_empty;
    mem_raddr  = idx_r;
    div_start  = 1'b0;
    tone_start = 1'b0;
    unique case (state_r)
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
      end
      S_CELL_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(item_r.target_cell);
      end
      S_CELL_RD: mem_raddr = AW'(item_r.target_cell);
      S_DIVGO:   div_start = 1'b1;
      S_SHADE:   tone_start = 1'b1;
      S_MEM_CHK: begin
        mem_we    = deeper;
        mem_wdata = '{depth: depth_r, tone: tone_new};
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
      nrm_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SWEEP) begin
        sweep_r <= sweep_r + AW'(1);
      end
      if (state_r == S_IDLE) begin
        nrm_r <= 1'b0;
      end else if (state_r == S_INDEX) begin
        nrm_r <= 1'b1;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_cos_r  <= TRIG_W'(4096);
      yaw_sin_r  <= '0;
      tilt_cos_r <= TRIG_W'(4096);
      tilt_sin_r <= '0;
      columns_r  <= COLS_REG_W'(80);
      rows_r     <= ROWS_REG_W'(24);
      scale_r    <= SCALE_W'(3072);
    end else if (cfg_wr) begin
      unique case (reg_t'(paddr[4:2]))
        REG_YAW_COS:  yaw_cos_r  <= TRIG_W'(pwdata);
        REG_YAW_SIN:  yaw_sin_r  <= TRIG_W'(pwdata);
        REG_TILT_COS: tilt_cos_r <= TRIG_W'(pwdata);
        REG_TILT_SIN: tilt_sin_r <= TRIG_W'(pwdata);
        REG_COLUMNS:  columns_r  <= COLS_REG_W'(pwdata);
        REG_ROWS:     rows_r     <= ROWS_REG_W'(pwdata);
        REG_SCALE:    scale_r    <= SCALE_W'(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_t'(paddr[4:2]))
      REG_YAW_COS:  prdata = CFG_DATA_W'(yaw_cos_r);
      REG_YAW_SIN:  prdata = CFG_DATA_W'(yaw_sin_r);
      REG_TILT_COS: prdata = CFG_DATA_W'(tilt_cos_r);
      REG_TILT_SIN: prdata = CFG_DATA_W'(tilt_sin_r);
      REG_COLUMNS:  prdata = CFG_DATA_W'(columns_r);
      REG_ROWS:     prdata = CFG_DATA_W'(rows_r);
      REG_SCALE:    prdata = CFG_DATA_W'(scale_r);
      default:      prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_r <= in_item;
          // clear and read echo empty depth; in-range reads and plots overwrite it
          res_r  <= '{cell_index: in_item.target_cell, cell_tone: '0,
                      cell_depth: (in_item.mode == MODE_CLEAR ||
                                   in_item.mode == MODE_READ) ? DEPTH_MIN : '0,
                      wrote: (in_item.mode == MODE_CLEAR) && !oor_c};
        end
      end
      S_ROT_A: begin
        rot0_r <= rot_sum(src_x, yaw_cos_r, src_z, yaw_sin_r);
        rot1_r <= rot_sum(-src_x, yaw_sin_r, src_z, yaw_cos_r);
      end
      S_ROT_B: begin
        if (nrm_r) begin
          nx_r <= rot0_r;
          ny_r <= rot_y;
          nz_r <= rot_z;
        end else begin
          rx_r <= rot0_r;
          ry_r <= rot_y;
          rz_r <= rot_z;
        end
      end
      S_PERSP: begin
        den_r  <= den_c;
        sgnx_r <= rx_r[ROT_W-1];
        sgny_r <= ry_r[ROT_W-1];
        p1x_r  <= P1_W'(magx) * P1_W'(scale_r);
        p1y_r  <= P1_W'(magy) * P1_W'(scale_r);
        res_r  <= '0;
      end
      S_SCALE: begin
        p2x_r <= P2_W'(p1x_r) * P2_W'(CAM_DIST);
        p2y_r <= P2_W'(p1y_r) * P2_W'(CAM_DIST);
      end
      S_PLACE: begin
        sx_r <= sx_c;
        sy_r <= sy_c;
        // saturate the rotated depth to the stored width
        if (rz_r > ROT_W'(DEPTH_MAX)) begin
          depth_r <= DEPTH_MAX;
        end else if (rz_r < ROT_W'(DEPTH_MIN)) begin
          depth_r <= DEPTH_MIN;
        end else begin
          depth_r <= DEPTH_W'(rz_r);
        end
      end
      S_INDEX: begin
        idx_r <= AW'(AW'(sy_r[RW-1:0]) * AW'(cols_eff) + AW'(sx_r[CW-1:0]));
      end
      S_MEM_CHK: begin
        res_r.cell_index <= IDX_W'(idx_r);
        if (deeper) begin
          res_r.cell_tone  <= tone_new;
          res_r.cell_depth <= depth_r;
          res_r.wrote      <= 1'b1;
        end else begin
          res_r.cell_tone  <= mem_rdata.tone;
          res_r.cell_depth <= mem_rdata.depth;
          res_r.wrote      <= 1'b0;
        end
      end
      S_CELL_WAIT: begin
        res_r.cell_tone  <= mem_rdata.tone;
        res_r.cell_depth <= mem_rdata.depth;
      end
      S_DONE: begin
        if (out_free) begin
          out_r <= res_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  zbps_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  zbps_div #(.W(DIV_W)) u_divx (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (divx_num),
    .den   (divx_den),
    .busy  (divx_busy),
    .quo   (divx_q)
  );

  zbps_div #(.W(DIV_W)) u_divy (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (divy_num),
    .den   (divy_den),
    .busy  (divy_busy),
    .quo   (divy_q)
  );

  zbps_tone u_tone (
    .clk   (clk),
    .rst_n (rst_n),
    .start (tone_start),
    .nx    (nx_r),
    .ny    (ny_r),
    .nz    (nz_r),
    .busy  (tone_busy),
    .tone  (tone_q)
  );

endmodule

`default_nettype wire

[sv/zbps_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// Standalone; defaults taken from zbps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zbps_ram #(
  parameter int WIDTH = zbps_pkg::CELL_W,
  parameter int DEPTH = zbps_pkg::MAX_COLUMNS_DEF * zbps_pkg::MAX_ROWS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/zbps_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on zbps_pkg for the default width.
`timescale 1ns / 1ps
`default_nettype none

module zbps_div #(
  parameter int W = zbps_pkg::DIV_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         busy,
  output logic [W-1:0] quo
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     acc_r;   // dividend out at the top, quotient in at the bottom
  logic [W:0]       rem_r;
  logic [W-1:0]     den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;

  logic [W:0] rem_sh;
  logic       ge;
  logic [W:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_r[W-1:0], acc_r[W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      acc_r  <= num;
      rem_r  <= '0;
      den_r  <= den;
      cnt_r  <= CNT_W'(W);
      busy_r <= 1'b1;
    end else if (busy_r) begin
      acc_r <= {acc_r[W-2:0], ge};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quo  = acc_r;

endmodule

`default_nettype wire

[sv/zbps_tone.sv]
// Lambert tone unit: compares the squared light dot product against nine
// squared thresholds in turn to pick tone 1..10. Uses zbps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zbps_tone (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [zbps_pkg::ROT_W-1:0]  nx,
  input  logic signed [zbps_pkg::ROT_W-1:0]  ny,
  input  logic signed [zbps_pkg::ROT_W-1:0]  nz,
  output logic                               busy,
  output logic [zbps_pkg::TONE_W-1:0]        tone
);

  import zbps_pkg::*;

  localparam logic signed [A_W-1:0] LX = A_W'(-35);
  localparam logic signed [A_W-1:0] LY = A_W'(55);
  localparam logic signed [A_W-1:0] LZ = A_W'(95);

  tone_state_t tstate_r, tstate_nxt;

  logic signed [ROT_W-1:0] nx_r, ny_r, nz_r;
  logic [S_W-1:0]          s_r;
  logic signed [A_W-1:0]   a_r;
  logic [AA_W-1:0]         aa_r;
  logic [BB_W-1:0]         bb_r;
  logic [3:0]              j_r;
  logic [TONE_W-1:0]       k_r;
  logic [TONE_W-1:0]       tone_r;

  logic signed [2*ROT_W-1:0] sqx, sqy, sqz;
  logic signed [A_W-1:0]     dot;
  logic [AM_W-1:0]           a_mag;
  logic                      a_neg;
  logic                      ok;
  logic [TONE_W-1:0]         k_inc;

  always_comb begin
    sqx   = (2*ROT_W)'(nx_r) * (2*ROT_W)'(nx_r);
    sqy   = (2*ROT_W)'(ny_r) * (2*ROT_W)'(ny_r);
    sqz   = (2*ROT_W)'(nz_r) * (2*ROT_W)'(nz_r);
    dot   = LX * A_W'(nx_r) + LY * A_W'(ny_r) + LZ * A_W'(nz_r);
    a_neg = a_r[A_W-1];
    a_mag = a_neg ? AM_W'(-a_r) : AM_W'(a_r);
    // thresholds from j = 5 upwards are positive
    if (j_r >= 4'd5) begin
      ok = !a_neg && (CMP_W'(aa_r) >= CMP_W'(bb_r));
    end else begin
      ok = !a_neg || (CMP_W'(aa_r) <= CMP_W'(bb_r));
    end
    k_inc = k_r + TONE_W'(ok);
  end

  always_comb begin
    tstate_nxt = tstate_r;
    unique case (tstate_r)
      T_IDLE:   if (start) tstate_nxt = T_PREP;
      T_PREP:   tstate_nxt = T_SQUARE;
      T_SQUARE: tstate_nxt = T_MUL;
      T_MUL:    tstate_nxt = T_CMP;
      T_CMP:    tstate_nxt = (j_r == 4'(TONE_STEPS)) ? T_IDLE : T_MUL;
      default:  tstate_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tstate_r <= T_IDLE;
    end else begin
      tstate_r <= tstate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (tstate_r)
      T_IDLE: begin
        if (start) begin
          nx_r <= nx;
          ny_r <= ny;
          nz_r <= nz;
        end
      end
      T_PREP: begin
        s_r <= S_W'(sqx) + S_W'(sqy) + S_W'(sqz);
        a_r <= A_W'(9) * dot;
      end
      T_SQUARE: begin
        aa_r <= AA_W'(a_mag) * AA_W'(a_mag);
        // a vanishing normal counts as unit length
        if (s_r <= S_W'(SMALL_NORM_SQ)) begin
          s_r <= S_W'(NORM_ONE_SQ);
        end
        j_r <= 4'd1;
        k_r <= '0;
      end
      T_MUL: begin
        bb_r <= BB_W'(thr_sq(j_r)) * BB_W'(s_r);
      end
      T_CMP: begin
        k_r <= k_inc;
        j_r <= j_r + 4'd1;
        if (j_r == 4'(TONE_STEPS)) begin
          tone_r <= k_inc + TONE_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign busy = (tstate_r != T_IDLE);
  assign tone = tone_r;

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for zbuffer_point_splat_shader_top: plots, clears and reads
// of the cell store, checked against a predictor of the block. Depends on zbps_pkg.
`timescale 1ns / 1ps

module testbench;
  import zbps_pkg::*;

  localparam int STORE_CELLS = MAX_COLUMNS_DEF * MAX_ROWS_DEF;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  zbuffer_point_splat_shader_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy of registers and cell store
  longint yaw_c, yaw_s, tilt_c, tilt_s;
  longint frame_cols, frame_rows_r, scale_r;
  shortint depth_mem[STORE_CELLS];
  logic [TONE_W-1:0] tone_mem[STORE_CELLS];
  int last_cell;

  out_item_t pending_results[$];
  int errors;
  int items_sent;
  int results_seen;
  int cells_written;
  bit gaps_on;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic longint round12(input longint v);
    return (v + 2048) >>> TRIG_FRAC;
  endfunction

  function automatic longint div_away(input longint num, input longint den);
    longint unsigned m;
    longint unsigned q;
    m = num < 0 ? longint'(-num) : num;
    q = (2 * m + den) / (2 * den);
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic void spin(input longint x, input longint y, input longint z,
                               output longint ox, output longint oy, output longint oz);
    longint fz;
    ox = round12(x * yaw_c + z * yaw_s);
    fz = round12(-x * yaw_s + z * yaw_c);
    oy = round12(y * tilt_c - fz * tilt_s);
    oz = round12(y * tilt_s + fz * tilt_c);
  endfunction

  function automatic logic [TONE_W-1:0] shade(input longint nx, input longint ny,
                                              input longint nz);
    longint unsigned s, aa, bb, am;
    longint a, b;
    int k;
    s = nx * nx + ny * ny + nz * nz;
    a = 9 * (-35 * nx + 55 * ny + 95 * nz);
    am = a < 0 ? longint'(-a) : a;
    aa = am * am;
    k = 0;
    if (s <= SMALL_NORM_SQ) s = NORM_ONE_SQ;
    for (int j = 1; j <= TONE_STEPS; j++) begin
      b = (2 * j - 9) * 100;
      bb = longint'(b * b) * s;
      if (b >= 0) begin
        if (a >= 0 && aa >= bb) k++;
      end else begin
        if (a >= 0 || aa <= bb) k++;
      end
    end
    return TONE_W'(1 + k);
  endfunction

  // works out the result of one item and updates the predicted store
  function automatic out_item_t splat_result(input in_item_t it);
    out_item_t r;
    longint cols, rows, rx, ry, rz, nx, ny, nz, den, sx, sy, dep;
    int idx;
    r = '0;
    if (it.mode == MODE_CLEAR || it.mode == MODE_READ) begin
      idx = it.target_cell;
      r.cell_index = it.target_cell;
      if (idx >= STORE_CELLS) begin
        r.cell_depth = DEPTH_MIN;
      end else if (it.mode == MODE_CLEAR) begin
        depth_mem[idx] = DEPTH_MIN;
        tone_mem[idx] = '0;
        r.cell_depth = DEPTH_MIN;
        r.wrote = 1'b1;
      end else begin
        r.cell_tone = tone_mem[idx];
        r.cell_depth = depth_mem[idx];
      end
      return r;
    end
    if (it.mode == MODE_NONE) begin
      r.cell_index = it.target_cell;
      return r;
    end
    cols = frame_cols > MAX_COLUMNS_DEF ? MAX_COLUMNS_DEF : frame_cols;
    rows = frame_rows_r > MAX_ROWS_DEF ? MAX_ROWS_DEF : frame_rows_r;
    spin(it.point_x, it.point_y, it.point_z, rx, ry, rz);
    den = CAM_DIST - rz;
    if (den <= NEAR_LIMIT) return r;
    sx = cols / 2 + div_away(rx * scale_r * CAM_DIST, den <<< DEN_SH);
    sy = rows / 2 - div_away(ry * scale_r * CAM_DIST * 13, (den <<< DEN_SH) * 25);
    if (sx < 1 || sx >= cols - 1 || sy < 0 || sy >= rows) return r;
    idx = int'(sy * cols + sx);
    dep = rz > 32767 ? 32767 : (rz < -32768 ? -32768 : rz);
    r.cell_index = IDX_W'(idx);
    if (dep <= depth_mem[idx]) begin
      r.cell_tone = tone_mem[idx];
      r.cell_depth = depth_mem[idx];
      return r;
    end
    depth_mem[idx] = shortint'(dep);
    if (it.is_hole) begin
      tone_mem[idx] = '0;
    end else begin
      spin(it.normal_x, it.normal_y, it.normal_z, nx, ny, nz);
      tone_mem[idx] = shade(nx, ny, nz);
    end
    r.cell_tone = tone_mem[idx];
    r.cell_depth = DEPTH_W'(dep);
    r.wrote = 1'b1;
    last_cell = idx;
    cells_written++;
    return r;
  endfunction

  task automatic send_item(input in_item_t it);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 36) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid = 1'b1;
    in_item = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(splat_result(it));
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic in_item_t point_item(input int x, input int y, input int z,
                                          input int nx, input int ny, input int nz,
                                          input bit hole);
    in_item_t it;
    it = '0;
    it.mode = MODE_PLOT;
    it.point_x = 16'(x);
    it.point_y = 16'(y);
    it.point_z = 16'(z);
    it.normal_x = 16'(nx);
    it.normal_y = 16'(ny);
    it.normal_z = 16'(nz);
    it.is_hole = hole;
    it.target_cell = IDX_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t cell_item(input mode_t m, input int target);
    in_item_t it;
    it = '0;
    it.mode = m;
    it.point_x = 16'($urandom);
    it.target_cell = IDX_W'(target);
    return it;
  endfunction

  // waits for every result, then for the block to go quiet
  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_t r, input int value);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = CFG_ADDR_W'(4 * int'(r));
    pwdata = CFG_DATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (r)
      REG_YAW_COS:  yaw_c = longint'(signed'(TRIG_W'(value)));
      REG_YAW_SIN:  yaw_s = longint'(signed'(TRIG_W'(value)));
      REG_TILT_COS: tilt_c = longint'(signed'(TRIG_W'(value)));
      REG_TILT_SIN: tilt_s = longint'(signed'(TRIG_W'(value)));
      REG_COLUMNS:  frame_cols = value & 'h1ff;
      REG_ROWS:     frame_rows_r = value & 'h7f;
      default:      scale_r = value & 'hffff;
    endcase
  endtask

  task automatic set_view(input int yc, input int ys, input int tc, input int ts,
                          input int cols, input int rows, input int scale);
    write_reg(REG_YAW_COS, yc);
    write_reg(REG_YAW_SIN, ys);
    write_reg(REG_TILT_COS, tc);
    write_reg(REG_TILT_SIN, ts);
    write_reg(REG_COLUMNS, cols);
    write_reg(REG_ROWS, rows);
    write_reg(REG_SCALE, scale);
  endtask

  function automatic in_item_t random_item();
    int pick;
    int c;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      if ($urandom_range(0, 6) == 0)
        return point_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom_range(0, 1));
      return point_item(int'($urandom_range(0, 24576)) - 12288,
                        int'($urandom_range(0, 24576)) - 12288,
                        int'($urandom_range(0, 28672)) - 12288,
                        $urandom, $urandom, $urandom, $urandom_range(0, 4) == 0);
    end
    c = $urandom_range(0, 1) ? last_cell : int'($urandom_range(0, STORE_CELLS - 1));
    if (pick < 82) return cell_item(MODE_CLEAR, c);
    if (pick < 96) return cell_item(MODE_READ, c);
    return cell_item(MODE_NONE, $urandom);
  endfunction

  task automatic test_directed();
    send_item(point_item(0, 0, 0, 0, 0, 4096, 0));
    send_item(point_item(0, 0, 0, 0, 0, 4096, 0));
    send_item(point_item(0, 0, 100, 0, 0, 0, 0));            // zero normal
    send_item(point_item(4096, 0, 0, 0, 0, 0, 1));           // hole
    send_item(point_item(0, 0, 16384, 0, 0, 4096, 0));      // at the near plane
    send_item(point_item(0, 0, 32767, 0, 0, 4096, 0));
    send_item(point_item(0, 4096, -32768, 0, 0, 4096, 0));
    send_item(point_item(32767, 0, 0, 0, 0, 4096, 0));
    send_item(point_item(-32768, -32768, 0, 0, 0, 4096, 0));
    send_item(point_item(-4096, 2048, 200, -1434, 2253, 3891, 0)); // facing light
    send_item(point_item(4096, 2048, 200, 1434, -2253, -3891, 0)); // facing away
    send_item(point_item(-4096, 2048, 300, 32767, -32768, 32767, 0));
    send_item(cell_item(MODE_READ, last_cell));
    send_item(cell_item(MODE_CLEAR, last_cell));
    send_item(cell_item(MODE_READ, last_cell));
    send_item(cell_item(MODE_NONE, STORE_CELLS - 1));
    send_item(cell_item(MODE_READ, 0));
    send_item(cell_item(MODE_CLEAR, STORE_CELLS - 1));
    send_item(cell_item(MODE_READ, STORE_CELLS - 1));
    drain();
  endtask

  task automatic run_phase(input int count);
    for (int i = 0; i < count; i++) send_item(random_item());
    drain();
  endtask

  task automatic test_extreme_views();
    // 45 degree views, widest frame, top scale; depth beyond 16 bits saturates
    set_view(2896, 2896, 2896, 2896, 256, 64, 65535);
    send_item(point_item(0, -32768, -32768, 0, 0, 4096, 0));
    send_item(point_item(0, -32768, -32768, 0, 0, 4096, 0));
    run_phase(60);
    // narrowest frame, zero scale: every kept point hits the same cell
    set_view(-4096, 0, 0, 4096, 3, 1, 0);
    run_phase(60);
    // frame registers above the store size
    set_view(4096, -4096, -4096, 4096, 511, 127, 1024);
    run_phase(60);
    // no rows: everything clips
    set_view(0, -4096, 4096, 0, 80, 0, 3072);
    run_phase(30);
  endtask

  task automatic test_random_views();
    for (int p = 0; p < 5; p++) begin
      set_view(int'($urandom_range(0, 8192)) - 4096, int'($urandom_range(0, 8192)) - 4096,
               int'($urandom_range(0, 8192)) - 4096, int'($urandom_range(0, 8192)) - 4096,
               $urandom_range(3, 256), $urandom_range(1, 64), $urandom_range(256, 8192));
      gaps_on = (p != 2);
      run_phase(90);
    end
    gaps_on = 1'b1;
  endtask

  // result checker
  initial begin
    out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_item);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_item.cell_index != want.cell_index) begin
            $display("%0t: cell_index expected %0d got %0d", $time, want.cell_index,
                     out_item.cell_index);
            errors++;
          end
          if (out_item.cell_tone != want.cell_tone) begin
            $display("%0t: cell_tone expected %0d got %0d", $time, want.cell_tone,
                     out_item.cell_tone);
            errors++;
          end
          if (out_item.cell_depth != want.cell_depth) begin
            $display("%0t: cell_depth expected %0d got %0d", $time, want.cell_depth,
                     out_item.cell_depth);
            errors++;
          end
          if (out_item.wrote != want.wrote) begin
            $display("%0t: wrote expected %0b got %0b", $time, want.wrote, out_item.wrote);
            errors++;
          end
        end
      end
    end
  end

  // receiver back-pressure
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = gaps_on && $urandom_range(0, 99) < 36;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    cells_written = 0;
    last_cell = 0;
    gaps_on = 1'b1;
    yaw_c = 4096;
    yaw_s = 0;
    tilt_c = 4096;
    tilt_s = 0;
    frame_cols = 80;
    frame_rows_r = 24;
    scale_r = 3072;
    for (int i = 0; i < STORE_CELLS; i++) begin
      depth_mem[i] = DEPTH_MIN;
      tone_mem[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_extreme_views();
    test_random_views();
    set_view(4096, 0, 4096, 0, 80, 24, 3072);
    run_phase(40);

    $display("%0d items sent, %0d results checked, %0d cells written", items_sent,
             results_seen, cells_written);
    $display("covered plot, clear, read and unused modes over 11 view settings");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
sv/zbps_pkg.sv
sv/zbps_ram.sv
sv/zbps_div.sv
sv/zbps_tone.sv
sv/zbuffer_point_splat_shader_top.sv
test/testbench.sv
